@@ rtl/sva_pkg.sv @@
package sva_pkg;

  localparam int ENTRIES_DEF       = 1024;
  localparam int HISTORY_DEPTH_DEF = 16;
  localparam int SNAPSHOT_BITS_DEF = 16;

  localparam int REQ_W    = 2;
  localparam int INDEX_W  = 10;
  localparam int VALUE_W  = 30;
  localparam int QUERY_W  = 16;
  localparam int TAKEN_W  = 16;
  localparam int STATUS_W = 3;
  localparam int LENGTH_W = 11;
  localparam int QUEUE_DEPTH = 2;
  // Wide enough for the largest snapshot counter the block supports.
  localparam int ID_W     = 32;

  typedef enum logic [REQ_W-1:0] {
    REQ_SET  = 2'd0,
    REQ_SNAP = 2'd1,
    REQ_GET  = 2'd2,
    REQ_NOP  = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_RANGE     = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_TAKEN = 3'd3,
    ST_EXHAUSTED = 3'd4
  } status_t;

  // Operation handed from the front end to the back end.
  typedef enum logic [1:0] {
    OP_SET,
    OP_GET,
    OP_DONE
  } op_t;

  // The id field holds the snapshot counter as it stood when the request was accepted.
  typedef struct packed {
    op_t                  op;
    logic [INDEX_W-1:0]   index;
    logic [VALUE_W-1:0]   value;
    logic [QUERY_W-1:0]   query;
    logic [TAKEN_W-1:0]   taken;
    logic [ID_W-1:0]      id;
    status_t              status;
  } job_t;

  typedef enum logic [2:0] {
    BE_IDLE,
    BE_CNT,
    BE_SRCH,
    BE_RD,
    BE_WR,
    BE_OUT
  } be_state_t;

endpackage

@@ rtl/snapshot_versioned_array.sv @@
// Versioned snapshot array with an in_valid/in_stall request channel, an out_valid/out_stall
// result channel and a one-register length port. Each request gives one result, and requests
// are carried out one at a time with a two-entry queue ahead of the back end. A snap or a
// rejected request goes from the queue straight to the output state; a set reads the entry's
// count, then its newest pair (not on an entry with no history), and writes; a get reads the
// count, then binary searches the entry's history, one search and one read state per step,
// set by the single read port of the history memory, and skips the capture state when no pair
// qualifies and the search on an empty history. After reset a clearing pass over all ENTRIES
// entries zeroes the per-entry counts; requests are queued but not carried out until it ends.
module snapshot_versioned_array #(
  parameter int ENTRIES       = sva_pkg::ENTRIES_DEF,
  parameter int HISTORY_DEPTH = sva_pkg::HISTORY_DEPTH_DEF,
  parameter int SNAPSHOT_BITS = sva_pkg::SNAPSHOT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sva_pkg::REQ_W-1:0]     in_req_type,
  input  logic [sva_pkg::INDEX_W-1:0]   in_entry_index,
  input  logic [sva_pkg::VALUE_W-1:0]   in_write_value,
  input  logic [sva_pkg::QUERY_W-1:0]   in_query_snapshot,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sva_pkg::VALUE_W-1:0]   out_read_value,
  output logic [sva_pkg::TAKEN_W-1:0]   out_taken_snapshot,
  output logic [sva_pkg::STATUS_W-1:0]  out_status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sva_pkg::LENGTH_W-1:0]  cfg_array_length
);

  logic [sva_pkg::LENGTH_W-1:0] length_r;
  logic                         q_full, q_push, q_pop, q_not_empty;
  sva_pkg::job_t                q_job, q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      length_r <= sva_pkg::LENGTH_W'(1024);
    end else if (cfg_valid) begin
      length_r <= cfg_array_length;
    end
  end

  sva_front #(.ENTRIES(ENTRIES), .SNAPSHOT_BITS(SNAPSHOT_BITS)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_req_type, .in_entry_index,
    .in_write_value, .in_query_snapshot, .length(length_r),
    .q_full, .q_push, .q_job
  );

  sva_queue u_queue (
    .clk, .rst_n, .push(q_push), .push_job(q_job), .full(q_full),
    .pop(q_pop), .not_empty(q_not_empty), .head(q_head)
  );

  sva_back #(
    .ENTRIES(ENTRIES), .HISTORY_DEPTH(HISTORY_DEPTH), .SNAPSHOT_BITS(SNAPSHOT_BITS)
  ) u_back (
    .clk, .rst_n, .q_not_empty, .q_head, .q_pop,
    .out_valid, .out_stall, .out_read_value, .out_taken_snapshot, .out_status
  );

endmodule

@@ rtl/sva_ram.sv @@
module sva_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/sva_front.sv @@
module sva_front #(
  parameter int ENTRIES       = sva_pkg::ENTRIES_DEF,
  parameter int SNAPSHOT_BITS = sva_pkg::SNAPSHOT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sva_pkg::REQ_W-1:0]     in_req_type,
  input  logic [sva_pkg::INDEX_W-1:0]   in_entry_index,
  input  logic [sva_pkg::VALUE_W-1:0]   in_write_value,
  input  logic [sva_pkg::QUERY_W-1:0]   in_query_snapshot,
  input  logic [sva_pkg::LENGTH_W-1:0]  length,
  input  logic                          q_full,
  output logic                          q_push,
  output sva_pkg::job_t                 q_job
);

  logic [SNAPSHOT_BITS-1:0] counter_r, counter_nxt;
  logic                     idx_ok;
  logic                     take;

  assign in_stall = q_full;
  assign take     = in_valid && !q_full;
  assign q_push   = take;

  always_comb begin
    if (32'(length) > 32'(ENTRIES)) begin
      idx_ok = 32'(in_entry_index) < 32'(ENTRIES);
    end else begin
      idx_ok = {1'b0, in_entry_index} < length;
    end
  end

  always_comb begin
    counter_nxt       = counter_r;
    q_job.op          = sva_pkg::OP_DONE;
    q_job.index       = in_entry_index;
    q_job.value       = in_write_value;
    q_job.query       = in_query_snapshot;
    q_job.taken       = '0;
    q_job.id          = sva_pkg::ID_W'(counter_r);
    q_job.status      = sva_pkg::ST_OK;
    case (sva_pkg::req_t'(in_req_type))
      sva_pkg::REQ_SET: begin
        if (idx_ok) begin
          q_job.op = sva_pkg::OP_SET;
        end else begin
          q_job.status = sva_pkg::ST_RANGE;
        end
      end
      sva_pkg::REQ_SNAP: begin
        if (&counter_r) begin
          q_job.status = sva_pkg::ST_EXHAUSTED;
        end else begin
          q_job.taken = sva_pkg::TAKEN_W'(counter_r);
          counter_nxt = counter_r + 1'b1;
        end
      end
      sva_pkg::REQ_GET: begin
        if (!idx_ok) begin
          q_job.status = sva_pkg::ST_RANGE;
        end else if (32'(in_query_snapshot) >= 32'(counter_r)) begin
          q_job.status = sva_pkg::ST_NOT_TAKEN;
        end else begin
          q_job.op = sva_pkg::OP_GET;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      counter_r <= '0;
    end else if (take) begin
      counter_r <= counter_nxt;
    end
  end

endmodule

@@ rtl/sva_queue.sv @@
module sva_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sva_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output sva_pkg::job_t head
);

  localparam int DEPTH = sva_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);

  sva_pkg::job_t       slot_r [DEPTH];
  logic [PW-1:0]       wp_r, rp_r;
  logic [PW:0]         cnt_r;

  assign full      = cnt_r == (PW+1)'(DEPTH);
  assign not_empty = cnt_r != '0;
  assign head      = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule

@@ rtl/sva_back.sv @@
module sva_back #(
  parameter int ENTRIES       = sva_pkg::ENTRIES_DEF,
  parameter int HISTORY_DEPTH = sva_pkg::HISTORY_DEPTH_DEF,
  parameter int SNAPSHOT_BITS = sva_pkg::SNAPSHOT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_not_empty,
  input  sva_pkg::job_t                 q_head,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sva_pkg::VALUE_W-1:0]   out_read_value,
  output logic [sva_pkg::TAKEN_W-1:0]   out_taken_snapshot,
  output logic [sva_pkg::STATUS_W-1:0]  out_status
);

  localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(HISTORY_DEPTH + 1);
  localparam int PD = ENTRIES * HISTORY_DEPTH;
  localparam int AW = $clog2(PD) > 0 ? $clog2(PD) : 1;
  localparam int PAIR_W = SNAPSHOT_BITS + sva_pkg::VALUE_W;

  sva_pkg::be_state_t state_r, state_nxt;
  sva_pkg::job_t      job_r;
  logic [CW-1:0]      lo_r, hi_r, n_r;
  logic [CW-1:0]      mid;
  logic               out_valid_r;
  logic [sva_pkg::VALUE_W-1:0]  rval_r;
  logic [sva_pkg::STATUS_W-1:0] st_r;
  logic [sva_pkg::TAKEN_W-1:0]  taken_r;
  logic [EW-1:0]      eidx;

  logic               cnt_we;
  logic [CW-1:0]      cnt_wdata, cnt_rdata;
  logic               pr_we;
  logic [AW-1:0]      pr_waddr, pr_raddr;
  logic [PAIR_W-1:0]  pr_wdata, pr_rdata;
  logic [SNAPSHOT_BITS-1:0] pr_id;
  logic [SNAPSHOT_BITS-1:0] set_id;
  logic [sva_pkg::VALUE_W-1:0] pr_val;
  logic               pending;
  logic               out_free;
  logic               finish;

  assign eidx   = EW'(job_r.index);
  assign set_id = SNAPSHOT_BITS'(job_r.id);
  assign mid    = CW'(({1'b0, lo_r} + {1'b0, hi_r}) >> 1);
  assign pr_id  = pr_rdata[PAIR_W-1 -: SNAPSHOT_BITS];
  assign pr_val = pr_rdata[sva_pkg::VALUE_W-1:0];
  assign out_free = !out_valid_r || !out_stall;

  // Per-entry fill counts are memory too, so reset runs a clearing pass.
  logic          clr_r;
  logic [EW:0]   clr_idx_r;

  sva_ram #(.WIDTH(CW), .DEPTH(ENTRIES)) u_cnt (
    .clk, .we(cnt_we),
    .waddr(clr_r ? clr_idx_r[EW-1:0] : eidx),
    .wdata(clr_r ? '0 : cnt_wdata),
    .raddr(EW'(q_head.index)), .rdata(cnt_rdata)
  );

  sva_ram #(.WIDTH(PAIR_W), .DEPTH(PD)) u_pairs (
    .clk, .we(pr_we), .waddr(pr_waddr), .wdata(pr_wdata),
    .raddr(pr_raddr), .rdata(pr_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_idx_r <= '0;
    end else if (clr_r) begin
      clr_idx_r <= clr_idx_r + 1'b1;
      if (clr_idx_r == (EW+1)'(ENTRIES - 1)) begin
        clr_r <= 1'b0;
      end
    end
  end

  function automatic logic [AW-1:0] paddr(input logic [EW-1:0] e, input logic [CW-1:0] k);
    paddr = AW'(e * HISTORY_DEPTH) + AW'(k);
  endfunction

  assign q_pop   = state_r == sva_pkg::BE_IDLE && q_not_empty && !clr_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sva_pkg::BE_IDLE: begin
        if (q_pop) begin
          state_nxt = (q_head.op == sva_pkg::OP_DONE) ? sva_pkg::BE_OUT : sva_pkg::BE_CNT;
        end
      end
      sva_pkg::BE_CNT: begin
        if (job_r.op == sva_pkg::OP_SET) begin
          state_nxt = (cnt_rdata == '0) ? sva_pkg::BE_WR : sva_pkg::BE_RD;
        end else begin
          state_nxt = (cnt_rdata == '0) ? sva_pkg::BE_OUT : sva_pkg::BE_SRCH;
        end
      end
      sva_pkg::BE_SRCH: begin
        state_nxt = sva_pkg::BE_RD;
      end
      sva_pkg::BE_RD: begin
        if (job_r.op == sva_pkg::OP_SET) begin
          state_nxt = sva_pkg::BE_WR;
        end else if (((pr_id <= SNAPSHOT_BITS'(job_r.query)) ? mid + 1'b1 : lo_r)
                     >= ((pr_id <= SNAPSHOT_BITS'(job_r.query)) ? hi_r : mid)) begin
          state_nxt = (pr_id <= SNAPSHOT_BITS'(job_r.query)) || (lo_r != '0)
                      ? sva_pkg::BE_WR : sva_pkg::BE_OUT;
        end else begin
          state_nxt = sva_pkg::BE_SRCH;
        end
      end
      sva_pkg::BE_WR: begin
        state_nxt = sva_pkg::BE_OUT;
      end
      sva_pkg::BE_OUT: begin
        if (out_free) begin
          state_nxt = sva_pkg::BE_IDLE;
        end
      end
      default: state_nxt = sva_pkg::BE_IDLE;
    endcase
  end

  // Set: the newest pair, read from BE_CNT on, is held through BE_WR, which writes.
  // Get: the final pair is read in BE_RD and captured in BE_WR.
  always_comb begin
    cnt_we    = clr_r;
    cnt_wdata = n_r + 1'b1;
    pr_we     = 1'b0;
    pr_waddr  = paddr(eidx, n_r);
    pr_wdata  = {set_id, job_r.value};
    pr_raddr  = paddr(eidx, mid);
    unique case (state_r)
      sva_pkg::BE_CNT: begin
        pr_raddr = paddr(eidx, cnt_rdata - 1'b1);
      end
      sva_pkg::BE_RD: begin
        if (job_r.op == sva_pkg::OP_GET) begin
          pr_raddr = paddr(eidx, ((pr_id <= SNAPSHOT_BITS'(job_r.query)) ? mid : lo_r) - 1'b1);
          if (pr_id <= SNAPSHOT_BITS'(job_r.query)) begin
            pr_raddr = paddr(eidx, mid);
          end
        end else begin
          pr_raddr = paddr(eidx, n_r - 1'b1);
        end
      end
      sva_pkg::BE_WR: begin
        if (job_r.op == sva_pkg::OP_SET) begin
          if (n_r != '0 && pr_id == set_id) begin
            pr_we    = 1'b1;
            pr_waddr = paddr(eidx, n_r - 1'b1);
          end else if (32'(n_r) < 32'(HISTORY_DEPTH)) begin
            pr_we  = 1'b1;
            cnt_we = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign finish = state_r == sva_pkg::BE_OUT && out_free;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_head;
    end
    unique case (state_r)
      sva_pkg::BE_CNT: begin
        n_r  <= cnt_rdata;
        lo_r <= '0;
        hi_r <= cnt_rdata;
        rval_r <= '0;
      end
      sva_pkg::BE_RD: begin
        if (job_r.op == sva_pkg::OP_GET) begin
          if (pr_id <= SNAPSHOT_BITS'(job_r.query)) begin
            lo_r <= mid + 1'b1;
          end else begin
            hi_r <= mid;
          end
        end
      end
      sva_pkg::BE_WR: begin
        if (job_r.op == sva_pkg::OP_SET) begin
          if (!(n_r != '0 && pr_id == set_id) && 32'(n_r) >= 32'(HISTORY_DEPTH)) begin
            job_r.status <= sva_pkg::ST_FULL;
          end
        end else begin
          rval_r <= pr_val;
        end
      end
      default: begin
      end
    endcase
  end

  assign pending = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sva_pkg::BE_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall || pending) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_read_value     <= (job_r.op == sva_pkg::OP_GET) ? rval_r : '0;
      out_taken_snapshot <= job_r.taken;
      out_status         <= job_r.status;
    end
  end

  assign out_valid = out_valid_r;

endmodule
